// ===== hdl/sfc_pkg.sv =====
// Shared constants and fixed-point helpers for the sphere frustum culler.
`timescale 1ns / 1ps
package sfc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;
    localparam logic [2:0] NO_PLANE = 3'd6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // magnitude of a signed 32-bit value, exact on 32 unsigned bits
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        begin
            m = v[31] ? (~v + 32'd1) : v;
            return m;
        end
    endfunction

    // attach a sign to a magnitude and clamp to 32-bit signed
    function automatic logic signed [31:0] sign_sat(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        begin
            if (neg) begin
                r = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
                r = ~r + 32'd1;
            end else begin
                r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
            end
            return $signed(r);
        end
    endfunction

    // saturating 32-bit add or subtract
    function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic sub);
        logic signed [32:0] s;
        logic signed [31:0] r;
        begin
            s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
            if (s[32] != s[31]) begin
                r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r = s[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/sphere_frustum_cull.sv =====
// Sphere versus view-frustum culler with a stored 4x4 Q format matrix.
`timescale 1ns / 1ps
// Usage:
//  Input channel (s_*): one beat is either a matrix element write (s_op = 0,
//  s_elem_index = column*4 + row, s_elem_value) or a sphere test (s_op = 1,
//  centre and radius). Every beat yields exactly one result beat on m_*.
//  Writes answer visible = 0, reject_plane = 6. Tests answer visible = 1 and
//  plane 6, or visible = 0 and the first plane (0..5) that rejected the sphere.
//  Steps: a write goes straight to the output register. A test runs one shared
//  sequencer for each plane in turn: matrix reads, squaring, a square root,
//  then 4 divisions by the normal length when that length is nonzero, then
//  the dot product. An early reject ends a test sooner; the long division
//  dominates.
//  s_ready is high only while the block is idle; one item is in flight.
//  The result is held in an output register until m_ready takes it; the block
//  accepts nothing until then.
//  Reset (aresetn low, synchronous) clears the matrix to zero through per-entry
//  valid bits and returns the sequencer to idle with no result pending.
module sphere_frustum_cull #(
    parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [3:0]         s_elem_index,
    input  logic signed [31:0] s_elem_value,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic signed [31:0] s_center_z,
    input  logic [30:0]        s_sphere_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic [2:0]         m_reject_plane
);

    localparam int DW = 32 + FRAC_BITS;        // dividend width
    localparam int CW = $clog2(DW + 33);       // step counter width

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DOT  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]         state_reg;
    logic [CW-1:0]      cnt_reg;
    logic [2:0]         plane_reg;

    // matrix memory with reset-clear valid bits
    logic [31:0]        mem [16];
    logic [15:0]        mem_vld_reg;
    logic [31:0]        rd_data_reg;
    logic [3:0]         rd_addr;

    logic signed [31:0] ctr_reg [3];
    logic [30:0]        radius_reg;
    logic signed [31:0] coef_reg [4];
    logic signed [31:0] a_reg;

    logic [63:0]        prod_reg;
    logic               prod_neg_reg;
    logic [63:0]        acc_reg;

    logic [63:0]        num_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;

    logic [1:0]         div_c_reg;
    logic               div_neg_reg;
    logic [DW-1:0]      div_sh_reg;
    logic [DW-1:0]      q_reg;
    logic [32:0]        rem_reg;

    logic               vis_reg;
    logic [2:0]         rej_reg;

    // read address: even steps fetch (c,3), odd steps fetch (c,k)
    logic [1:0] rd_col;
    logic [1:0] rd_row;
    assign rd_col  = cnt_reg[2:1];
    assign rd_row  = cnt_reg[0] ? plane_reg[2:1] : 2'd3;
    assign rd_addr = {rd_col, rd_row};

    // square root step
    logic [63:0] sq_trial;
    logic        sq_ge;
    assign sq_trial = res_reg + bit_reg;
    assign sq_ge    = (num_reg >= sq_trial);

    // restoring division step
    logic [33:0] dv_trial;
    logic        dv_ge;
    logic [33:0] dv_diff;
    logic [32:0] len;
    assign len      = res_reg[32:0];
    assign dv_trial = {rem_reg, div_sh_reg[DW-1]};
    assign dv_ge    = (dv_trial >= {1'b0, len});
    assign dv_diff  = dv_trial - {1'b0, len};

    // product term after scaling and clamping
    logic signed [31:0] term;
    assign term = sfc_pkg::sign_sat(prod_reg >> FRAC_BITS, prod_neg_reg);

    logic [63:0] acc_sum;
    assign acc_sum = acc_reg + 64'($signed(term));

    logic [63:0] sq_sum;
    assign sq_sum = acc_reg + prod_reg;

    logic [1:0] ci;
    assign ci = cnt_reg[1:0];

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_op == sfc_pkg::OP_WRITE) begin
            mem[s_elem_index] <= s_elem_value;
        end
        rd_data_reg <= mem_vld_reg[rd_addr] ? mem[rd_addr] : 32'd0;
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mem_vld_reg <= '0;
            cnt_reg     <= '0;
            plane_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_op == sfc_pkg::OP_WRITE) begin
                            mem_vld_reg[s_elem_index] <= 1'b1;
                            vis_reg   <= 1'b0;
                            rej_reg   <= sfc_pkg::NO_PLANE;
                            state_reg <= ST_OUT;
                        end else begin
                            ctr_reg[0] <= s_center_x;
                            ctr_reg[1] <= s_center_y;
                            ctr_reg[2] <= s_center_z;
                            radius_reg <= s_sphere_radius;
                            plane_reg  <= 3'd0;
                            cnt_reg    <= '0;
                            state_reg  <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    // data for step cnt-1 arrives now
                    if (cnt_reg != '0) begin
                        if (!cnt_reg[0]) begin
                            coef_reg[2'(CW'(cnt_reg - CW'(1)) >> 1)] <=
                                sfc_pkg::sat_addsub(a_reg, $signed(rd_data_reg),
                                                    plane_reg[0]);
                        end else begin
                            a_reg <= $signed(rd_data_reg);
                        end
                    end
                    if (cnt_reg == CW'(8)) begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_SQ;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_SQ: begin
                    if (cnt_reg != CW'(3)) begin
                        prod_reg <= 64'(sfc_pkg::mag32(coef_reg[ci]))
                                  * 64'(sfc_pkg::mag32(coef_reg[ci]));
                    end
                    if (cnt_reg != '0) begin
                        acc_reg <= sq_sum;
                    end
                    if (cnt_reg == CW'(3)) begin
                        num_reg   <= sq_sum;
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= ST_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_SQRT: begin
                    if (bit_reg == '0) begin
                        cnt_reg   <= '0;
                        div_c_reg <= 2'd0;
                        state_reg <= (res_reg == '0) ? ST_DOT : ST_DIV;
                        acc_reg   <= 64'(coef_reg[3]);
                    end else begin
                        if (sq_ge) begin
                            num_reg <= num_reg - sq_trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        div_sh_reg  <= {sfc_pkg::mag32(coef_reg[div_c_reg]),
                                        FRAC_BITS'(0)};
                        div_neg_reg <= coef_reg[div_c_reg][31];
                        rem_reg     <= '0;
                        q_reg       <= '0;
                        cnt_reg     <= cnt_reg + CW'(1);
                    end else if (cnt_reg == CW'(DW + 1)) begin
                        coef_reg[div_c_reg] <= sfc_pkg::sign_sat(64'(q_reg), div_neg_reg);
                        cnt_reg <= '0;
                        if (div_c_reg == 2'd3) begin
                            state_reg <= ST_DOT;
                            acc_reg   <= 64'(sfc_pkg::sign_sat(64'(q_reg), div_neg_reg));
                        end else begin
                            div_c_reg <= div_c_reg + 2'd1;
                        end
                    end else begin
                        rem_reg    <= dv_ge ? dv_diff[32:0] : dv_trial[32:0];
                        q_reg      <= {q_reg[DW-2:0], dv_ge};
                        div_sh_reg <= div_sh_reg << 1;
                        cnt_reg    <= cnt_reg + CW'(1);
                    end
                end
                ST_DOT: begin
                    if (cnt_reg != CW'(3)) begin
                        prod_reg <= 64'(sfc_pkg::mag32(coef_reg[ci]))
                                  * 64'(sfc_pkg::mag32(ctr_reg[ci]));
                        prod_neg_reg <= coef_reg[ci][31] ^ ctr_reg[ci][31];
                    end
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_sum;
                    end
                    if (cnt_reg == CW'(3)) begin
                        cnt_reg <= '0;
                        if ($signed(acc_sum) < -$signed({33'd0, radius_reg})) begin
                            vis_reg   <= 1'b0;
                            rej_reg   <= plane_reg;
                            state_reg <= ST_OUT;
                        end else if (plane_reg == 3'(sfc_pkg::NUM_PLANES - 1)) begin
                            vis_reg   <= 1'b1;
                            rej_reg   <= sfc_pkg::NO_PLANE;
                            state_reg <= ST_OUT;
                        end else begin
                            plane_reg <= plane_reg + 3'd1;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_OUT);
    assign m_visible      = vis_reg;
    assign m_reject_plane = rej_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the sphere frustum culler: matrix writes and sphere tests.
`timescale 1ns / 1ps
module tb;

    localparam int FB = sfc_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 400;

    // Predicts cull results from its own copy of the matrix and queues them
    class cull_scoreboard;
        logic signed [31:0] mat [16];
        logic [2:0] exp_plane_q [$];
        logic       exp_vis_q [$];
        int mismatches;
        int checked;
        int rejects;

        function new();
            foreach (mat[i]) mat[i] = '0;
            mismatches = 0;
            checked = 0;
            rejects = 0;
        endfunction

        function automatic longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic logic [63:0] root64(logic [63:0] num);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > num) bitv >>= 2;
            while (bitv != 0) begin
                if (num >= res + bitv) begin
                    num -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function automatic longint signed_clamp(logic [63:0] m, bit neg);
            if (neg) begin
                if (m > 64'h8000_0000) m = 64'h8000_0000;
                return -longint'(m);
            end
            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
            return longint'(m);
        endfunction

        function automatic logic [63:0] absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        // append one expected result beat
        function void add_expect(logic vis, logic [2:0] plane);
            exp_vis_q = {exp_vis_q, vis};
            exp_plane_q = {exp_plane_q, plane};
        endfunction

        // note an accepted input beat and queue its expected result
        function void note_input(logic op, logic [3:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] cx, logic signed [31:0] cy,
                                 logic signed [31:0] cz, logic [30:0] rad);
            longint ctr [3];
            longint coef [4];
            longint plane_dist;
            logic [63:0] sq;
            logic [63:0] len;
            logic [63:0] q;
            int k;
            logic [2:0] hit;
            if (op == sfc_pkg::OP_WRITE) begin
                mat[idx] = val;
                add_expect(1'b0, sfc_pkg::NO_PLANE);
                return;
            end
            ctr[0] = cx;
            ctr[1] = cy;
            ctr[2] = cz;
            hit = sfc_pkg::NO_PLANE;
            for (int p = 0; p < sfc_pkg::NUM_PLANES && hit == sfc_pkg::NO_PLANE; p++) begin
                k = p >> 1;
                for (int c = 0; c < 4; c++) begin
                    if (p & 1) coef[c] = clamp32(longint'(mat[c*4+3]) - mat[c*4+k]);
                    else       coef[c] = clamp32(longint'(mat[c*4+3]) + mat[c*4+k]);
                end
                sq = 0;
                for (int c = 0; c < 3; c++) sq += absval(coef[c]) * absval(coef[c]);
                len = root64(sq);
                if (len != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        q = (absval(coef[c]) << FB) / len;
                        coef[c] = signed_clamp(q, coef[c] < 0);
                    end
                end
                plane_dist = coef[3];
                for (int c = 0; c < 3; c++) begin
                    q = (absval(coef[c]) * absval(ctr[c])) >> FB;
                    plane_dist += signed_clamp(q, (coef[c] < 0) != (ctr[c] < 0));
                end
                if (plane_dist < -longint'(rad)) hit = 3'(p);
            end
            if (hit != sfc_pkg::NO_PLANE) rejects++;
            add_expect(hit == sfc_pkg::NO_PLANE, hit);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic vis, logic [2:0] plane);
            logic ev;
            logic [2:0] ep;
            checked++;
            if (exp_vis_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result beat");
                return;
            end
            ev = exp_vis_q.pop_front();
            ep = exp_plane_q.pop_front();
            if (vis !== ev || plane !== ep) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: exp vis=%0d plane=%0d, got vis=%0d plane=%0d",
                             checked, ev, ep, vis, plane);
            end
        endfunction

        function int pending();
            return exp_vis_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_op;
    logic [3:0] s_elem_index;
    logic signed [31:0] s_elem_value;
    logic signed [31:0] s_center_x;
    logic signed [31:0] s_center_y;
    logic signed [31:0] s_center_z;
    logic [30:0] s_sphere_radius;
    logic m_valid;
    logic m_ready;
    logic m_visible;
    logic [2:0] m_reject_plane;

    cull_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int n_writes;
    int n_tests;

    sphere_frustum_cull #(.FRAC_BITS(FB)) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_elem_index   (s_elem_index),
        .s_elem_value   (s_elem_value),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_center_z     (s_center_z),
        .s_sphere_radius(s_sphere_radius),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_visible      (m_visible),
        .m_reject_plane (m_reject_plane)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stall, check each accepted beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_visible, m_reject_plane);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // send one beat, with random idle cycles ahead of it
    task automatic send_beat(logic op, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [30:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_elem_index <= idx;
        s_elem_value <= val;
        s_center_x <= cx;
        s_center_y <= cy;
        s_center_z <= cz;
        s_sphere_radius <= rad;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(op, idx, val, cx, cy, cz, rad);
        if (op == sfc_pkg::OP_WRITE) n_writes++;
        else n_tests++;
    endtask

    task automatic write_elem(logic [3:0] idx, logic [31:0] val);
        send_beat(sfc_pkg::OP_WRITE, idx, val, $urandom, $urandom, $urandom,
                  31'($urandom));
    endtask

    task automatic test_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [30:0] rad);
        send_beat(sfc_pkg::OP_TEST, 4'($urandom), $urandom, cx, cy, cz, rad);
    endtask

    // a small coordinate, mostly within a few units of the origin
    function automatic logic [31:0] coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $signed($urandom_range(20 << FB)) - (10 << FB);
        endcase
    endfunction

    function automatic logic [31:0] mat_value();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 0;
            default: return $signed($urandom_range(4 << FB)) - (2 << FB);
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                write_elem(4'($urandom), mat_value());
            else
                test_sphere(coord(), coord(), coord(),
                            31'(($urandom_range(7) == 0) ? $urandom
                                                         : $urandom_range(3 << FB)));
        end
    endtask

    initial begin
        sb = new();
        n_writes = 0;
        n_tests = 0;
        send_idle_pct = 22;
        recv_idle_pct = 50;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = sfc_pkg::OP_WRITE;
        s_elem_index = '0;
        s_elem_value = '0;
        s_center_x = '0;
        s_center_y = '0;
        s_center_z = '0;
        s_sphere_radius = '0;
        m_ready = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero matrix, then identity-like frustum and extremes
        test_sphere(0, 0, 0, 31'd0);
        test_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        for (int i = 0; i < 16; i++)
            write_elem(4'(i), ((i & 3) == (i >> 2)) ? (1 << FB) : 0);
        test_sphere(0, 0, 0, 31'(1 << FB));
        test_sphere(5 << FB, 0, 0, 31'(1 << FB));
        test_sphere(-(5 << FB), 0, 0, 31'd0);
        test_sphere(0, 32'h8000_0000, 0, 31'd0);
        test_sphere(0, 0, 32'h7FFF_FFFF, 31'd0);
        // saturating coefficients
        write_elem(4'd15, 32'h7FFF_FFFF);
        write_elem(4'd0, 32'h7FFF_FFFF);
        write_elem(4'd12, 32'h8000_0000);
        test_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'd0);

        random_phase(N_RANDOM / 3);
        send_idle_pct = 50;
        recv_idle_pct = 22;
        random_phase(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(N_RANDOM / 3);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d element writes and %0d sphere tests (%0d rejected).",
                 n_writes, n_tests, sb.rejects);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog: tests are long, and the bench adds random stalls
    initial begin
        #50_000_000;
        $display("ERROR: timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/sfc_pkg.sv
hdl/sphere_frustum_cull.sv
bench/tb.sv
